// File: design/rbs_pkg.sv
// rbs_pkg: types, codes and the key function shared by the record sort core
// and its table cells. No dependencies.
// The record cell and the top level both take everything by scoped name.
package rbs_pkg;

  localparam int TABLE_DEPTH_DEF = 64;

  // sort key modes
  localparam logic [1:0] MODE_INVALID = 2'd0;
  localparam logic [1:0] MODE_NAME    = 2'd1;
  localparam logic [1:0] MODE_DATE    = 2'd2;
  localparam logic [1:0] MODE_ID      = 2'd3;

  // result status codes
  localparam logic [1:0] STATUS_OK     = 2'd0;
  localparam logic [1:0] STATUS_EMPTY  = 2'd1;
  localparam logic [1:0] STATUS_BADKEY = 2'd2;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_SORT = 1'b1;

  typedef struct packed {
    logic        operation;
    logic [9:0]  record_id;
    logic [63:0] name_prefix;
    logic [4:0]  day_of_month;
    logic [3:0]  month_number;
    logic [11:0] year_number;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [9:0]  out_id;
    logic [63:0] out_name;
    logic [4:0]  out_day;
    logic [3:0]  out_month;
    logic [11:0] out_year;
    logic        last_flag;
  } rsp_t;

  typedef struct packed {
    logic [9:0]  id;
    logic [63:0] name;
    logic [4:0]  day;
    logic [3:0]  month;
    logic [11:0] year;
  } rec_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_LOAD,
    CELL_SWAP,
    CELL_ROTATE
  } cell_op_t;

  typedef struct packed {
    cell_op_t   op;
    logic       parity;
    logic [1:0] mode;
  } cell_ctrl_t;

  // name bytes after the first zero byte do not take part in the order
  function automatic logic [63:0] sort_key(rec_t r, logic [1:0] mode);
    logic [63:0] canon;
    logic        keep;
    canon = '0;
    keep  = 1'b1;
    for (int k = 7; k >= 0; k--) begin
      if (keep) canon[8*k +: 8] = r.name[8*k +: 8];
      if (r.name[8*k +: 8] == 8'd0) keep = 1'b0;
    end
    case (mode)
      MODE_NAME: sort_key = canon;
      MODE_DATE: sort_key = {43'd0, r.year, r.month, r.day};
      default:   sort_key = {54'd0, r.id};
    endcase
  endfunction

endpackage

// File: design/rbs_cell.sv
// rbs_cell: one table slot of the record sort core. Holds one record, takes it
// from the load port, and trades it with its neighbors for odd-even sort phases and rotation.
// Depends on rbs_pkg.
module rbs_cell #(
  parameter int TABLE_DEPTH = rbs_pkg::TABLE_DEPTH_DEF,
  parameter int CELL_INDEX  = 0,
  localparam int CNT_W      = $clog2(TABLE_DEPTH + 1)
) (
  input  logic               clk,
  input  rbs_pkg::cell_ctrl_t ctrl,
  input  logic [CNT_W-1:0]   count,
  input  rbs_pkg::rec_t      load_rec,
  input  rbs_pkg::rec_t      head_rec,
  input  rbs_pkg::rec_t      left_rec,
  input  logic               left_swap,
  input  rbs_pkg::rec_t      right_rec,
  output rbs_pkg::rec_t      rec,
  output logic               swap_right
);

  localparam logic IDX_PAR = 1'(CELL_INDEX % 2);

  logic has_right;
  logic is_tail;

  assign has_right = CNT_W'(CELL_INDEX + 1) < count;
  assign is_tail   = CNT_W'(CELL_INDEX + 1) == count;

  // this cell is left of the pair with its right neighbor
  assign swap_right = has_right &&
      (rbs_pkg::sort_key(rec, ctrl.mode) > rbs_pkg::sort_key(right_rec, ctrl.mode));

  always_ff @(posedge clk) begin
    unique case (ctrl.op)
      rbs_pkg::CELL_LOAD: begin
        if (count == CNT_W'(CELL_INDEX)) rec <= load_rec;
      end
      rbs_pkg::CELL_SWAP: begin
        if (IDX_PAR == ctrl.parity) begin
          if (swap_right) rec <= right_rec;
        end else if (left_swap) begin
          rec <= left_rec;
        end
      end
      rbs_pkg::CELL_ROTATE: begin
        if (is_tail) rec <= head_rec;
        else if (has_right) rec <= right_rec;
      end
      default: ;
    endcase
  end

endmodule

// File: design/record_bubble_sort_core.sv
// record_bubble_sort_core: record table with an in-place stable sort by name,
// date or id, built as a row of record cells. Depends on rbs_pkg and rbs_cell.
//
// Usage
//   req (req_valid / req_stall): one word per item. A load word stores a record
//   in the next free cell; loads are taken back to back. A load
//   into a full table is dropped. A sort word runs odd-even transposition
//   phases over the row, one phase per cycle, N phases for N stored records,
//   then rotates the row once, showing cell 0 on rsp before each step, so the table
//   keeps its sorted order afterwards.
//   rsp (rsp_valid / rsp_stall): N record words, last_flag on the final one.
//   A sort with key mode 0 gives one error word, an empty table one empty
//   word; the word is shown the cycle after the sort word is taken and carries
//   last_flag.
//   After the sort word is taken the phases run, then the record words follow,
//   one word per cycle while rsp_stall is low. req_stall is high from the sort
//   word until its last word is taken.
//   rsp_stall holds the word shown and freezes the rotation.
//   cfg (cfg_valid / cfg_ready): the 2-bit key mode, always ready; the user must
//   write it only while idle, which the block does not enforce. Reset clears the
//   record count and sets the key mode to id; the cell contents are left as they are.
module record_bubble_sort_core #(
  parameter int TABLE_DEPTH = rbs_pkg::TABLE_DEPTH_DEF,
  localparam int CNT_W      = $clog2(TABLE_DEPTH + 1)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  rbs_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output rbs_pkg::rsp_t rsp,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [1:0]    cfg_data
);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SORT   = 4'b0010,
    ST_EMIT   = 4'b0100,
    ST_REPORT = 4'b1000
  } state_t;

  state_t            state, state_next;
  logic [CNT_W-1:0]  count, count_next;
  logic [CNT_W-1:0]  step, step_next;
  logic [1:0]        status_code, status_code_next;
  logic [1:0]        mode;
  logic              req_take;
  logic              rsp_take;
  logic              last_step;
  rbs_pkg::cell_ctrl_t ctrl;
  rbs_pkg::rec_t     load_rec;
  rbs_pkg::rec_t     cell_rec [TABLE_DEPTH];
  logic              cell_swap [TABLE_DEPTH];

  assign cfg_ready = 1'b1;
  assign req_stall = state != ST_IDLE;
  assign req_take  = req_valid && !req_stall;
  assign rsp_valid = (state == ST_EMIT) || (state == ST_REPORT);
  assign rsp_take  = rsp_valid && !rsp_stall;
  assign last_step = step == (count - CNT_W'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= rbs_pkg::MODE_ID;
    end else if (cfg_valid && cfg_ready) begin
      mode <= cfg_data;
    end
  end

  assign load_rec.id    = req.record_id;
  assign load_rec.name  = req.name_prefix;
  assign load_rec.day   = req.day_of_month;
  assign load_rec.month = req.month_number;
  assign load_rec.year  = req.year_number;

  always_comb begin
    state_next       = state;
    count_next       = count;
    step_next        = step;
    status_code_next = status_code;
    ctrl.op          = rbs_pkg::CELL_HOLD;
    ctrl.parity      = step[0];
    ctrl.mode        = mode;
    unique case (state)
      ST_IDLE: begin
        if (req_take) begin
          if (req.operation == rbs_pkg::OP_LOAD) begin
            if (count < CNT_W'(TABLE_DEPTH)) begin
              ctrl.op    = rbs_pkg::CELL_LOAD;
              count_next = count + CNT_W'(1);
            end
          end else if (mode == rbs_pkg::MODE_INVALID) begin
            status_code_next = rbs_pkg::STATUS_BADKEY;
            state_next       = ST_REPORT;
          end else if (count == '0) begin
            status_code_next = rbs_pkg::STATUS_EMPTY;
            state_next       = ST_REPORT;
          end else begin
            step_next  = '0;
            state_next = ST_SORT;
          end
        end
      end
      ST_SORT: begin
        ctrl.op = rbs_pkg::CELL_SWAP;
        if (last_step) begin
          step_next  = '0;
          state_next = ST_EMIT;
        end else begin
          step_next = step + CNT_W'(1);
        end
      end
      ST_EMIT: begin
        if (rsp_take) begin
          ctrl.op = rbs_pkg::CELL_ROTATE;
          if (last_step) state_next = ST_IDLE;
          else step_next = step + CNT_W'(1);
        end
      end
      ST_REPORT: begin
        if (rsp_take) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
      step  <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
      step  <= step_next;
    end
    status_code <= status_code_next;
  end

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    rbs_pkg::rec_t left_rec;
    rbs_pkg::rec_t right_rec;
    logic          left_swap;

    if (i == 0) begin : g_head
      assign left_rec  = cell_rec[i];
      assign left_swap = 1'b0;
    end else begin : g_mid
      assign left_rec  = cell_rec[i-1];
      assign left_swap = cell_swap[i-1];
    end

    if (i == TABLE_DEPTH - 1) begin : g_end
      assign right_rec = cell_rec[i];
    end else begin : g_inner
      assign right_rec = cell_rec[i+1];
    end

    rbs_cell #(
      .TABLE_DEPTH(TABLE_DEPTH),
      .CELL_INDEX (i)
    ) u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .count     (count),
      .load_rec  (load_rec),
      .head_rec  (cell_rec[0]),
      .left_rec  (left_rec),
      .left_swap (left_swap),
      .right_rec (right_rec),
      .rec       (cell_rec[i]),
      .swap_right(cell_swap[i])
    );
  end

  always_comb begin
    rsp = '0;
    if (state == ST_EMIT) begin
      rsp.status    = rbs_pkg::STATUS_OK;
      rsp.out_id    = cell_rec[0].id;
      rsp.out_name  = cell_rec[0].name;
      rsp.out_day   = cell_rec[0].day;
      rsp.out_month = cell_rec[0].month;
      rsp.out_year  = cell_rec[0].year;
      rsp.last_flag = last_step;
    end else if (state == ST_REPORT) begin
      rsp.status    = status_code;
      rsp.last_flag = 1'b1;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(TABLE_DEPTH))
    else $error("record count beyond table depth");

  a_count_frozen: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |=> $stable(count))
    else $error("record count changed during a sort");

  a_step_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SORT || state == ST_EMIT) |-> (step < count))
    else $error("phase or emit step beyond record count");

  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    (rsp_take && rsp.last_flag) |=> (state == ST_IDLE))
    else $error("last word taken but run did not end");

endmodule

// File: tb/record_order_checker.sv
// record_order_checker: watches the req, rsp and cfg channels of the record
// sort core, keeps its own copy of the table and key mode, and checks every rsp word.
// Depends on rbs_pkg.
`timescale 1ns / 100ps

module record_order_checker (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  input  logic          req_stall,
  input  rbs_pkg::req_t req,
  input  logic          rsp_valid,
  input  logic          rsp_stall,
  input  rbs_pkg::rsp_t rsp,
  input  logic          cfg_valid,
  input  logic          cfg_ready,
  input  logic [1:0]    cfg_data,
  output int            pending_words,
  output int            mismatch_count
);

  localparam int DEPTH = rbs_pkg::TABLE_DEPTH_DEF;

  rbs_pkg::rec_t table_rows [DEPTH];
  int            stored;
  logic [1:0]    key_mode;
  rbs_pkg::rsp_t expected_words [$];
  int            errors = 0;

  // strict order only, so equal keys never swap
  function automatic bit goes_after(rbs_pkg::rec_t a, rbs_pkg::rec_t b, logic [1:0] mode);
    logic [7:0] ca, cb;
    if (mode == rbs_pkg::MODE_NAME) begin
      for (int k = 7; k >= 0; k--) begin
        ca = a.name[8*k +: 8];
        cb = b.name[8*k +: 8];
        if (ca != cb) return ca > cb;
        // shared terminator: rest of the name does not count
        if (ca == 8'd0) return 1'b0;
      end
      return 1'b0;
    end
    if (mode == rbs_pkg::MODE_DATE)
      return {a.year, a.month, a.day} > {b.year, b.month, b.day};
    return a.id > b.id;
  endfunction

  function automatic void apply_request(rbs_pkg::req_t w);
    rbs_pkg::rsp_t word;
    rbs_pkg::rec_t held;
    if (w.operation == rbs_pkg::OP_LOAD) begin
      // full table drops the record
      if (stored < DEPTH) begin
        table_rows[stored] = '{id: w.record_id, name: w.name_prefix, day: w.day_of_month,
                               month: w.month_number, year: w.year_number};
        stored++;
      end
      return;
    end
    word = '0;
    word.last_flag = 1'b1;
    if (key_mode == rbs_pkg::MODE_INVALID) begin
      word.status = rbs_pkg::STATUS_BADKEY;
      expected_words.push_back(word);
      return;
    end
    if (stored == 0) begin
      word.status = rbs_pkg::STATUS_EMPTY;
      expected_words.push_back(word);
      return;
    end
    for (int i = 0; i + 1 < stored; i++)
      for (int j = 0; j + 1 < stored - i; j++)
        if (goes_after(table_rows[j], table_rows[j+1], key_mode)) begin
          held            = table_rows[j];
          table_rows[j]   = table_rows[j+1];
          table_rows[j+1] = held;
        end
    for (int i = 0; i < stored; i++) begin
      word.status    = rbs_pkg::STATUS_OK;
      word.out_id    = table_rows[i].id;
      word.out_name  = table_rows[i].name;
      word.out_day   = table_rows[i].day;
      word.out_month = table_rows[i].month;
      word.out_year  = table_rows[i].year;
      word.last_flag = (i == stored - 1);
      expected_words.push_back(word);
    end
  endfunction

  function automatic void compare_word(rbs_pkg::rsp_t got);
    rbs_pkg::rsp_t want;
    if (expected_words.size() == 0) begin
      errors++;
      $display("%0t: rsp word with nothing expected: %h", $time, got);
      return;
    end
    want = expected_words.pop_front();
    if (got === want) return;
    errors++;
    if (got.status !== want.status)
      $display("%0t: status expected %0d got %0d", $time, want.status, got.status);
    if (got.out_id !== want.out_id)
      $display("%0t: out_id expected %0d got %0d", $time, want.out_id, got.out_id);
    if (got.out_name !== want.out_name)
      $display("%0t: out_name expected %h got %h", $time, want.out_name, got.out_name);
    if (got.out_day !== want.out_day)
      $display("%0t: out_day expected %0d got %0d", $time, want.out_day, got.out_day);
    if (got.out_month !== want.out_month)
      $display("%0t: out_month expected %0d got %0d", $time, want.out_month, got.out_month);
    if (got.out_year !== want.out_year)
      $display("%0t: out_year expected %0d got %0d", $time, want.out_year, got.out_year);
    if (got.last_flag !== want.last_flag)
      $display("%0t: last_flag expected %0d got %0d", $time, want.last_flag, got.last_flag);
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      stored   = 0;
      key_mode = rbs_pkg::MODE_ID;
      expected_words.delete();
    end else begin
      if (cfg_valid && cfg_ready) key_mode = cfg_data;
      if (req_valid && !req_stall) apply_request(req);
      if (rsp_valid === 1'b1 && !rsp_stall) compare_word(rsp);
    end
    pending_words  <= expected_words.size();
    mismatch_count <= errors;
  end

endmodule

// File: tb/tb.sv
// tb: top of the record sort core testbench; drives req, cfg and rsp stall
// and gives the verdict. Depends on rbs_pkg, record_bubble_sort_core, record_order_checker.
`timescale 1ns / 100ps

module tb;

  logic          clk       = 1'b0;
  logic          rst       = 1'b1;
  logic          req_valid = 1'b0;
  logic          req_stall;
  rbs_pkg::req_t req       = '0;
  logic          rsp_valid;
  logic          rsp_stall = 1'b0;
  rbs_pkg::rsp_t rsp;
  logic          cfg_valid = 1'b0;
  logic          cfg_ready;
  logic [1:0]    cfg_data  = rbs_pkg::MODE_ID;
  int            pending_words;
  int            mismatch_count;
  int            send_idle = 0;
  int            recv_idle = 0;

  always #10 clk = ~clk;

  always @(posedge clk) begin
    rsp_stall <= ($urandom_range(99) < recv_idle);
  end

  record_bubble_sort_core u_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  record_order_checker u_checker (
    .clk            (clk),
    .rst            (rst),
    .req_valid      (req_valid),
    .req_stall      (req_stall),
    .req            (req),
    .rsp_valid      (rsp_valid),
    .rsp_stall      (rsp_stall),
    .rsp            (rsp),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data),
    .pending_words  (pending_words),
    .mismatch_count (mismatch_count)
  );

  task automatic send_word(rbs_pkg::req_t w);
    while ($urandom_range(99) < send_idle) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req       <= w;
    @(posedge clk);
    while (req_stall) @(posedge clk);
  endtask

  // hold off until every expected word is out and the last load has settled
  task automatic wait_idle();
    req_valid <= 1'b0;
    @(posedge clk);
    while (pending_words != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_mode(logic [1:0] m);
    cfg_valid <= 1'b1;
    cfg_data  <= m;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic rbs_pkg::req_t load_word(logic [9:0] id, logic [63:0] name,
                                              logic [4:0] day, logic [3:0] month,
                                              logic [11:0] year);
    rbs_pkg::req_t w;
    w = '{operation: rbs_pkg::OP_LOAD, record_id: id, name_prefix: name,
          day_of_month: day, month_number: month, year_number: year};
    return w;
  endfunction

  // short names from a small alphabet so that ties and shared prefixes are common
  function automatic logic [63:0] short_name(int len, bit junk);
    logic [63:0] n;
    n = '0;
    for (int k = 0; k < 8; k++)
      if (k < len) n[8*(7-k) +: 8] = 8'h61 + 8'($urandom_range(3));
      else if (k > len && junk) n[8*(7-k) +: 8] = 8'($urandom);
    return n;
  endfunction

  function automatic rbs_pkg::req_t random_record();
    rbs_pkg::req_t w;
    w.operation = rbs_pkg::OP_LOAD;
    w.record_id = $urandom_range(1) ? 10'($urandom_range(1023)) : 10'($urandom_range(7));
    if ($urandom_range(3) == 0) w.name_prefix = {$urandom, $urandom};
    else w.name_prefix = short_name($urandom_range(8), $urandom_range(3) == 0);
    case ($urandom_range(4))
      0: begin
        w.day_of_month = 5'($urandom);
        w.month_number = 4'($urandom);
        w.year_number  = 12'($urandom);
      end
      1, 2: begin
        w.day_of_month = 5'($urandom_range(3, 1));
        w.month_number = 4'($urandom_range(2, 1));
        w.year_number  = 12'($urandom_range(2025, 2024));
      end
      default: begin
        w.day_of_month = 5'($urandom_range(31, 1));
        w.month_number = 4'($urandom_range(12, 1));
        w.year_number  = 12'($urandom_range(2050, 2024));
      end
    endcase
    return w;
  endfunction

  function automatic rbs_pkg::req_t sort_word();
    rbs_pkg::req_t w;
    w = random_record();
    w.operation = rbs_pkg::OP_SORT;
    return w;
  endfunction

  initial begin
    #(10_000_000);
    $display("FAILED: results differ");
    $finish;
  end

  initial begin
    int idle_cycles;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty table, then a bad key which wins over the empty check
    send_word(sort_word());
    wait_idle();
    write_mode(rbs_pkg::MODE_INVALID);
    send_word(sort_word());
    wait_idle();
    write_mode(rbs_pkg::MODE_ID);

    send_word(load_word(10'd1023, 64'hFFFF_FFFF_FFFF_FFFF, 5'd31, 4'd15, 12'd4095));
    send_word(load_word(10'd0, 64'h0, 5'd0, 4'd0, 12'd0));
    // same name up to the terminator, differing bytes after it
    send_word(load_word(10'd5, 64'h6162_0078_797A_0000, 5'd1, 4'd1, 12'd2024));
    send_word(load_word(10'd5, 64'h6162_0000_0000_0000, 5'd1, 4'd1, 12'd2024));
    send_word(load_word(10'd512, 64'h6162_6300_0000_0000, 5'd15, 4'd6, 12'd2037));
    send_word(load_word(10'd341, 64'h8000_0000_0000_0001, 5'd31, 4'd12, 12'd2050));
    send_word(load_word(10'd682, 64'h6162_6300_0000_0000, 5'd15, 4'd6, 12'd2037));
    send_word(load_word(10'd1, 64'h7A7A_7A7A_7A7A_7A7A, 5'd1, 4'd12, 12'd2024));
    send_word(sort_word());
    wait_idle();
    // bad key must leave the table as it was
    write_mode(rbs_pkg::MODE_INVALID);
    send_word(sort_word());
    wait_idle();
    write_mode(rbs_pkg::MODE_NAME);
    send_word(sort_word());
    wait_idle();
    write_mode(rbs_pkg::MODE_DATE);
    send_word(sort_word());
    wait_idle();
    write_mode(rbs_pkg::MODE_ID);
    send_word(sort_word());

    for (int phase = 0; phase < 3; phase++) begin
      send_idle = (phase == 0) ? 24 : (phase == 1) ? 56 : 0;
      recv_idle = (phase == 0) ? 56 : (phase == 1) ? 24 : 0;
      for (int chunk = 0; chunk < 4; chunk++) begin
        wait_idle();
        write_mode(2'(chunk + phase));
        for (int n = 0; n < 27; n++) begin
          if ($urandom_range(7) == 0) send_word(sort_word());
          else send_word(random_record());
          if ($urandom_range(29) == 0) wait_idle();
        end
      end
    end

    req_valid <= 1'b0;
    idle_cycles = 0;
    @(posedge clk);
    while (pending_words != 0 && idle_cycles < 100000) begin
      @(posedge clk);
      idle_cycles++;
    end
    if (pending_words != 0) begin
      $display("FAILED: results differ");
    end else begin
      repeat (20) @(posedge clk);
      if (mismatch_count == 0) begin
        $display("PASSED: all results match");
      end else begin
        $display("FAILED: results differ");
      end
    end
    $finish;
  end

endmodule
